[design/nmea_rmc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_rmc_pkg
// Shared constants, types and helper functions of the RMC sentence parser.
// ----------------------------------------------------------------------------
package nmea_rmc_pkg;

    localparam int FRAC_DIGITS = 5;
    localparam int MAX_FIELDS  = 15;

    localparam int FIELD_W   = 4;
    localparam int DPOS_W    = 3;
    localparam int FD_W      = 3;
    localparam int PAIR_W    = 7;
    localparam int YEAR_W    = 7;
    localparam int CFG_IDX_W = 1;
    localparam int EVENT_W   = 2;

    localparam logic [2:0] PREFIX_LEN  = 3'd7;
    localparam logic [2:0] DP_STOP     = 3'd7;
    localparam logic [2:0] PAIR_DIGITS = 3'd6;
    localparam logic [2:0] STATUS_CAP  = 3'd2;
    localparam logic [FD_W-1:0] FD_MAX = FD_W'(FRAC_DIGITS);

    localparam logic [FIELD_W-1:0] FLD_TIME     = 4'd1;
    localparam logic [FIELD_W-1:0] FLD_STATUS   = 4'd2;
    localparam logic [FIELD_W-1:0] FLD_LAT      = 4'd3;
    localparam logic [FIELD_W-1:0] FLD_LAT_HEMI = 4'd4;
    localparam logic [FIELD_W-1:0] FLD_LON      = 4'd5;
    localparam logic [FIELD_W-1:0] FLD_LON_HEMI = 4'd6;
    localparam logic [FIELD_W-1:0] FLD_DATE     = 4'd9;
    localparam logic [FIELD_W-1:0] FLD_MAX      = FIELD_W'(MAX_FIELDS);

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_W      = 8'h57;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_C      = 8'h43;

    localparam int FRAC_SCALE = 10 ** FRAC_DIGITS;
    localparam int FRAC_W     = $clog2(FRAC_SCALE + 1);

    localparam int LAT_WHOLE_W   = 14;
    localparam int LON_WHOLE_W   = 17;
    localparam int LAT_WHOLE_MAX = 2 ** LAT_WHOLE_W - 1;
    localparam int LON_WHOLE_MAX = 2 ** LON_WHOLE_W - 1;
    localparam int LAT_V_W       = LAT_WHOLE_W + 4;
    localparam int LON_V_W       = LON_WHOLE_W + 4;
    localparam int LAT_DEG_SAT   = LAT_WHOLE_MAX / 100;
    localparam int LON_DEG_SAT   = LON_WHOLE_MAX / 100;
    localparam int LAT_REM_SAT   = LAT_WHOLE_MAX % 100;
    localparam int LON_REM_SAT   = LON_WHOLE_MAX % 100;
    localparam int LAT_DEG_W     = $clog2(LAT_DEG_SAT + 1);
    localparam int LON_DEG_W     = $clog2(LON_DEG_SAT + 1);
    localparam int REM_W         = 7;
    localparam int REM_T_W       = 10;
    localparam int CARRY_W       = 4;

    localparam int MINV_W     = $clog2(100 * FRAC_SCALE);
    localparam int DIV6_SHIFT = MINV_W + 3;
    localparam int DIV6_W     = MINV_W + 1;
    localparam longint unsigned DIV6_MULT = ((64'd1 << DIV6_SHIFT) + 64'd5) / 64'd6;
    localparam int PROD_W     = MINV_W + DIV6_W;
    localparam int Q_W        = $clog2(100 * FRAC_SCALE / 6 + 1);

    localparam int MICRO       = 1000000;
    localparam int LAT_OUT_W   = 27;
    localparam int LON_OUT_W   = 30;
    localparam int LAT_OUT_MAX = 99999999;
    localparam int LON_OUT_MAX = 999999999;
    localparam int LAT_SUM_W   = $clog2(LAT_DEG_SAT * MICRO + 100 * FRAC_SCALE / 6 + 1);
    localparam int LON_SUM_W   = $clog2(LON_DEG_SAT * MICRO + 100 * FRAC_SCALE / 6 + 1);

    localparam int EV_SET_CLOCK  = 0;
    localparam int EV_FIX_GAINED = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_YEAR_MIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_YEAR_MAX = 1'b1;
    localparam logic [YEAR_W-1:0] YEAR_MIN_RESET = 7'd21;
    localparam logic [YEAR_W-1:0] YEAR_MAX_RESET = 7'd50;

    typedef struct packed {
        logic [PAIR_W-1:0]    hour;
        logic [PAIR_W-1:0]    minute;
        logic [PAIR_W-1:0]    second;
        logic [PAIR_W-1:0]    day;
        logic [PAIR_W-1:0]    month;
        logic [PAIR_W-1:0]    year;
        logic                 position_valid;
        logic [LAT_OUT_W-1:0] lat_microdeg;
        logic                 lat_south;
        logic [LON_OUT_W-1:0] lon_microdeg;
        logic                 lon_west;
        logic [EVENT_W-1:0]   event_res;
    } t_result;

    function automatic logic f_is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic [7:0] f_prefix_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0: ch = CH_DOLLAR;
            3'd1: ch = CH_G;
            3'd2: ch = CH_P;
            3'd3: ch = CH_R;
            3'd4: ch = CH_M;
            3'd5: ch = CH_C;
            3'd6: ch = CH_COMMA;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [FRAC_W-1:0] f_pow10(input logic [FD_W-1:0] n);
        logic [FRAC_W-1:0] p;
        case (n)
            3'd0: p = FRAC_W'(1);
            3'd1: p = FRAC_W'(10);
            3'd2: p = FRAC_W'(100);
            3'd3: p = FRAC_W'(1000);
            3'd4: p = FRAC_W'(10000);
            3'd5: p = FRAC_W'(100000);
            3'd6: p = FRAC_W'(1000000);
            default: p = FRAC_W'(1);
        endcase
        return p;
    endfunction

    // hundreds digit of a value below 1000
    function automatic logic [CARRY_W-1:0] f_div100(input logic [REM_T_W-1:0] t);
        logic [CARRY_W-1:0] q;
        q = '0;
        for (int i = 1; i < 10; i++) begin
            if (t >= REM_T_W'(100 * i)) begin
                q = CARRY_W'(i);
            end
        end
        return q;
    endfunction

endpackage

[design/nmea_rmc_sentence_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_rmc_sentence_parser
// Character-at-a-time parser for RMC sentences, reporting time, date,
// position and clock/fix events once per complete sentence.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one received character per word on i_rx_char, taken when
//   i_valid is high and o_stall is low; while o_stall is low, one character
//   per cycle is sustained, each a digit accumulate and compare on the state.
//   Output channel: one result word per sentence ending in '*', CR or LF that
//   reached the date field, shown on o_valid and taken when i_stall is low.
//   The result word is registered when its terminating character is taken.
//   Coordinate conversion to microdegrees runs in a three-register pipeline
//   behind the parser state; the sentence layout leaves it settled before
//   any terminator.
//   A result register and a skid register part the two sides: while the
//   receiver stalls, characters are still taken until a second result is
//   held, then o_stall rises until the receiver drains one.
//   Configuration: i_cfg_index selects year_min (0) or year_max (1), written
//   when i_cfg_valid is high; o_cfg_ready is always high.
//   Reset (i_rst_n low, synchronous) drops any sentence in progress and any
//   pending results, restores the year window to 21..50 and clears the
//   clock-set and fix history.
// ----------------------------------------------------------------------------
module nmea_rmc_sentence_parser (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [7:0]                             i_rx_char,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic [nmea_rmc_pkg::PAIR_W-1:0]        o_hour,
    output logic [nmea_rmc_pkg::PAIR_W-1:0]        o_minute,
    output logic [nmea_rmc_pkg::PAIR_W-1:0]        o_second,
    output logic [nmea_rmc_pkg::PAIR_W-1:0]        o_day,
    output logic [nmea_rmc_pkg::PAIR_W-1:0]        o_month,
    output logic [nmea_rmc_pkg::PAIR_W-1:0]        o_year,
    output logic                                   o_position_valid,
    output logic [nmea_rmc_pkg::LAT_OUT_W-1:0]     o_lat_microdeg,
    output logic                                   o_lat_south,
    output logic [nmea_rmc_pkg::LON_OUT_W-1:0]     o_lon_microdeg,
    output logic                                   o_lon_west,
    output logic [nmea_rmc_pkg::EVENT_W-1:0]       o_event_res,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [nmea_rmc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [nmea_rmc_pkg::YEAR_W-1:0]        i_cfg_data
);

    // configuration
    logic [nmea_rmc_pkg::YEAR_W-1:0] r_year_min;
    logic [nmea_rmc_pkg::YEAR_W-1:0] r_year_max;

    // sentence control
    logic [2:0]                          r_prefix_pos,  n_prefix_pos;
    logic                                r_in_sentence, n_in_sentence;
    logic [nmea_rmc_pkg::FIELD_W-1:0]    r_field_count, n_field_count;
    logic [nmea_rmc_pkg::DPOS_W-1:0]     r_digit_pos,   n_digit_pos;
    logic [nmea_rmc_pkg::FD_W-1:0]       r_frac_digits, n_frac_digits;
    logic                                r_after_point, n_after_point;
    logic                                r_clock_set_done, n_clock_set_done;
    logic                                r_fix_held,    n_fix_held;

    // field accumulators
    logic [nmea_rmc_pkg::PAIR_W-1:0]     r_time_acc [3];
    logic [nmea_rmc_pkg::PAIR_W-1:0]     n_time_acc [3];
    logic [nmea_rmc_pkg::PAIR_W-1:0]     r_date_acc [3];
    logic [nmea_rmc_pkg::PAIR_W-1:0]     n_date_acc [3];
    logic                                r_status_ok, n_status_ok;
    logic [1:0]                          r_hemi, n_hemi;
    logic [nmea_rmc_pkg::LAT_WHOLE_W-1:0] r_lat_whole, n_lat_whole;
    logic [nmea_rmc_pkg::LAT_DEG_W-1:0]  r_lat_deg, n_lat_deg;
    logic [nmea_rmc_pkg::REM_W-1:0]      r_lat_rem, n_lat_rem;
    logic [nmea_rmc_pkg::FRAC_W-1:0]     r_lat_frac, n_lat_frac;
    logic [nmea_rmc_pkg::LON_WHOLE_W-1:0] r_lon_whole, n_lon_whole;
    logic [nmea_rmc_pkg::LON_DEG_W-1:0]  r_lon_deg, n_lon_deg;
    logic [nmea_rmc_pkg::REM_W-1:0]      r_lon_rem, n_lon_rem;
    logic [nmea_rmc_pkg::FRAC_W-1:0]     r_lon_frac, n_lon_frac;

    // coordinate conversion pipeline
    logic [nmea_rmc_pkg::MINV_W-1:0]     r_lat_minv, r_lon_minv;
    logic [nmea_rmc_pkg::PROD_W-1:0]     lat_div_prod, lon_div_prod;
    logic [nmea_rmc_pkg::Q_W-1:0]        r_lat_q, r_lon_q;
    logic [nmea_rmc_pkg::LAT_SUM_W-1:0]  lat_sum;
    logic [nmea_rmc_pkg::LON_SUM_W-1:0]  lon_sum;
    logic [nmea_rmc_pkg::LAT_OUT_W-1:0]  r_lat_out;
    logic [nmea_rmc_pkg::LON_OUT_W-1:0]  r_lon_out;

    // per-character helpers
    logic                                in_acc;
    logic                                out_take;
    logic                                is_dig;
    logic                                is_term;
    logic [3:0]                          dig;
    logic [1:0]                          pair_k;
    logic [nmea_rmc_pkg::PAIR_W-1:0]     pair_acc;
    logic [nmea_rmc_pkg::PAIR_W-1:0]     pair_new;
    logic [nmea_rmc_pkg::FRAC_W-1:0]     cur_frac;
    logic [nmea_rmc_pkg::FRAC_W-1:0]     frac_step;
    logic [nmea_rmc_pkg::FRAC_W-1:0]     scale_pow;
    logic [2*nmea_rmc_pkg::FRAC_W-1:0]   scale_prod;
    logic [nmea_rmc_pkg::LAT_V_W-1:0]    lat_v;
    logic [nmea_rmc_pkg::LON_V_W-1:0]    lon_v;
    logic [nmea_rmc_pkg::REM_T_W-1:0]    lat_t, lon_t;
    logic [nmea_rmc_pkg::CARRY_W-1:0]    lat_carry, lon_carry;
    logic                                year_in_win;

    // result path
    logic                                res_v;
    logic [nmea_rmc_pkg::EVENT_W-1:0]    ev;
    nmea_rmc_pkg::t_result               res;
    nmea_rmc_pkg::t_result               r_out;
    nmea_rmc_pkg::t_result               r_skid;
    logic                                r_out_valid;
    logic                                r_skid_valid;

    assign o_stall     = r_skid_valid;
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_valid && !r_skid_valid;
    assign out_take    = r_out_valid && !i_stall;

    assign is_dig  = nmea_rmc_pkg::f_is_digit(i_rx_char);
    assign is_term = (i_rx_char == nmea_rmc_pkg::CH_STAR) || (i_rx_char == nmea_rmc_pkg::CH_CR)
                     || (i_rx_char == nmea_rmc_pkg::CH_LF);
    assign dig     = 4'(i_rx_char - nmea_rmc_pkg::CH_ZERO);

    assign pair_k   = r_digit_pos[2:1];
    assign pair_acc = (r_field_count == nmea_rmc_pkg::FLD_DATE) ? r_date_acc[pair_k]
                                                                : r_time_acc[pair_k];
    assign pair_new = nmea_rmc_pkg::PAIR_W'(pair_acc * 10 + dig);

    assign cur_frac   = (r_field_count == nmea_rmc_pkg::FLD_LON) ? r_lon_frac : r_lat_frac;
    assign frac_step  = nmea_rmc_pkg::FRAC_W'(cur_frac * 10 + dig);
    assign scale_pow  = nmea_rmc_pkg::f_pow10(nmea_rmc_pkg::FD_MAX - r_frac_digits);
    assign scale_prod = (2*nmea_rmc_pkg::FRAC_W)'(cur_frac) * (2*nmea_rmc_pkg::FRAC_W)'(scale_pow);

    assign lat_v     = nmea_rmc_pkg::LAT_V_W'(r_lat_whole * 10 + dig);
    assign lon_v     = nmea_rmc_pkg::LON_V_W'(r_lon_whole * 10 + dig);
    assign lat_t     = nmea_rmc_pkg::REM_T_W'(r_lat_rem * 10 + dig);
    assign lon_t     = nmea_rmc_pkg::REM_T_W'(r_lon_rem * 10 + dig);
    assign lat_carry = nmea_rmc_pkg::f_div100(lat_t);
    assign lon_carry = nmea_rmc_pkg::f_div100(lon_t);

    assign year_in_win = (r_date_acc[2] >= r_year_min) && (r_date_acc[2] <= r_year_max);

    // parser next state
    always_comb begin
        n_prefix_pos     = r_prefix_pos;
        n_in_sentence    = r_in_sentence;
        n_field_count    = r_field_count;
        n_digit_pos      = r_digit_pos;
        n_frac_digits    = r_frac_digits;
        n_after_point    = r_after_point;
        n_clock_set_done = r_clock_set_done;
        n_fix_held       = r_fix_held;
        n_time_acc       = r_time_acc;
        n_date_acc       = r_date_acc;
        n_status_ok      = r_status_ok;
        n_hemi           = r_hemi;
        n_lat_whole      = r_lat_whole;
        n_lat_deg        = r_lat_deg;
        n_lat_rem        = r_lat_rem;
        n_lat_frac       = r_lat_frac;
        n_lon_whole      = r_lon_whole;
        n_lon_deg        = r_lon_deg;
        n_lon_rem        = r_lon_rem;
        n_lon_frac       = r_lon_frac;
        res_v            = 1'b0;
        ev               = '0;

        if (in_acc) begin
            if (i_rx_char == nmea_rmc_pkg::CH_DOLLAR) begin
                n_in_sentence = 1'b1;
                n_prefix_pos  = 3'd1;
                n_field_count = '0;
                n_digit_pos   = '0;
                n_frac_digits = '0;
                n_after_point = 1'b0;
                n_time_acc    = '{default: '0};
                n_date_acc    = '{default: '0};
                n_status_ok   = 1'b0;
                n_hemi        = '0;
                n_lat_whole   = '0;
                n_lat_deg     = '0;
                n_lat_rem     = '0;
                n_lat_frac    = '0;
                n_lon_whole   = '0;
                n_lon_deg     = '0;
                n_lon_rem     = '0;
                n_lon_frac    = '0;
            end else if (r_in_sentence) begin
                if (r_prefix_pos < nmea_rmc_pkg::PREFIX_LEN) begin
                    if (i_rx_char == nmea_rmc_pkg::f_prefix_char(r_prefix_pos)) begin
                        n_prefix_pos = r_prefix_pos + 3'd1;
                        if (r_prefix_pos == nmea_rmc_pkg::PREFIX_LEN - 3'd1) begin
                            n_field_count = nmea_rmc_pkg::FLD_TIME;
                            n_digit_pos   = '0;
                            n_frac_digits = '0;
                            n_after_point = 1'b0;
                        end
                    end else begin
                        n_in_sentence = 1'b0;
                    end
                end else if (is_term) begin
                    n_in_sentence = 1'b0;
                    if (r_field_count >= nmea_rmc_pkg::FLD_DATE) begin
                        res_v = 1'b1;
                        if (year_in_win && !r_clock_set_done) begin
                            ev[nmea_rmc_pkg::EV_SET_CLOCK] = 1'b1;
                            n_clock_set_done = 1'b1;
                        end
                        if (r_status_ok) begin
                            ev[nmea_rmc_pkg::EV_FIX_GAINED] = !r_fix_held;
                            n_fix_held = 1'b1;
                        end else begin
                            n_fix_held = 1'b0;
                        end
                    end
                end else if (i_rx_char == nmea_rmc_pkg::CH_COMMA) begin
                    // minute decimals are left-aligned to the full digit count
                    if (r_field_count == nmea_rmc_pkg::FLD_LAT) begin
                        n_lat_frac = scale_prod[nmea_rmc_pkg::FRAC_W-1:0];
                    end else if (r_field_count == nmea_rmc_pkg::FLD_LON) begin
                        n_lon_frac = scale_prod[nmea_rmc_pkg::FRAC_W-1:0];
                    end
                    if (r_field_count < nmea_rmc_pkg::FLD_MAX) begin
                        n_field_count = r_field_count + 4'd1;
                    end
                    n_digit_pos   = '0;
                    n_frac_digits = '0;
                    n_after_point = 1'b0;
                end else begin
                    case (r_field_count)
                        nmea_rmc_pkg::FLD_TIME: begin
                            if (r_digit_pos < nmea_rmc_pkg::PAIR_DIGITS && is_dig) begin
                                n_time_acc[pair_k] = pair_new;
                                n_digit_pos = r_digit_pos + 3'd1;
                            end else begin
                                n_digit_pos = nmea_rmc_pkg::DP_STOP;
                            end
                        end
                        nmea_rmc_pkg::FLD_DATE: begin
                            if (r_digit_pos < nmea_rmc_pkg::PAIR_DIGITS && is_dig) begin
                                n_date_acc[pair_k] = pair_new;
                                n_digit_pos = r_digit_pos + 3'd1;
                            end else begin
                                n_digit_pos = nmea_rmc_pkg::DP_STOP;
                            end
                        end
                        nmea_rmc_pkg::FLD_STATUS: begin
                            n_status_ok = (r_digit_pos == '0) && (i_rx_char == nmea_rmc_pkg::CH_A);
                            if (r_digit_pos < nmea_rmc_pkg::STATUS_CAP) begin
                                n_digit_pos = r_digit_pos + 3'd1;
                            end
                        end
                        nmea_rmc_pkg::FLD_LAT: begin
                            if (r_digit_pos != nmea_rmc_pkg::DP_STOP) begin
                                if (is_dig) begin
                                    if (r_after_point) begin
                                        if (r_frac_digits < nmea_rmc_pkg::FD_MAX) begin
                                            n_lat_frac    = frac_step;
                                            n_frac_digits = r_frac_digits + 3'd1;
                                        end
                                    end else if (lat_v > nmea_rmc_pkg::LAT_WHOLE_MAX) begin
                                        n_lat_whole = nmea_rmc_pkg::LAT_WHOLE_W'(
                                                          nmea_rmc_pkg::LAT_WHOLE_MAX);
                                        n_lat_deg   = nmea_rmc_pkg::LAT_DEG_W'(
                                                          nmea_rmc_pkg::LAT_DEG_SAT);
                                        n_lat_rem   = nmea_rmc_pkg::REM_W'(
                                                          nmea_rmc_pkg::LAT_REM_SAT);
                                    end else begin
                                        n_lat_whole = lat_v[nmea_rmc_pkg::LAT_WHOLE_W-1:0];
                                        n_lat_deg   = nmea_rmc_pkg::LAT_DEG_W'(
                                                          r_lat_deg * 10 + lat_carry);
                                        n_lat_rem   = nmea_rmc_pkg::REM_W'(
                                                          lat_t - lat_carry * 100);
                                    end
                                end else if (i_rx_char == nmea_rmc_pkg::CH_POINT
                                             && !r_after_point) begin
                                    n_after_point = 1'b1;
                                end else begin
                                    n_digit_pos = nmea_rmc_pkg::DP_STOP;
                                end
                            end
                        end
                        nmea_rmc_pkg::FLD_LON: begin
                            if (r_digit_pos != nmea_rmc_pkg::DP_STOP) begin
                                if (is_dig) begin
                                    if (r_after_point) begin
                                        if (r_frac_digits < nmea_rmc_pkg::FD_MAX) begin
                                            n_lon_frac    = frac_step;
                                            n_frac_digits = r_frac_digits + 3'd1;
                                        end
                                    end else if (lon_v > nmea_rmc_pkg::LON_WHOLE_MAX) begin
                                        n_lon_whole = nmea_rmc_pkg::LON_WHOLE_W'(
                                                          nmea_rmc_pkg::LON_WHOLE_MAX);
                                        n_lon_deg   = nmea_rmc_pkg::LON_DEG_W'(
                                                          nmea_rmc_pkg::LON_DEG_SAT);
                                        n_lon_rem   = nmea_rmc_pkg::REM_W'(
                                                          nmea_rmc_pkg::LON_REM_SAT);
                                    end else begin
                                        n_lon_whole = lon_v[nmea_rmc_pkg::LON_WHOLE_W-1:0];
                                        n_lon_deg   = nmea_rmc_pkg::LON_DEG_W'(
                                                          r_lon_deg * 10 + lon_carry);
                                        n_lon_rem   = nmea_rmc_pkg::REM_W'(
                                                          lon_t - lon_carry * 100);
                                    end
                                end else if (i_rx_char == nmea_rmc_pkg::CH_POINT
                                             && !r_after_point) begin
                                    n_after_point = 1'b1;
                                end else begin
                                    n_digit_pos = nmea_rmc_pkg::DP_STOP;
                                end
                            end
                        end
                        nmea_rmc_pkg::FLD_LAT_HEMI: begin
                            if (r_digit_pos == '0 && i_rx_char == nmea_rmc_pkg::CH_S) begin
                                n_hemi[0] = 1'b1;
                            end
                            n_digit_pos = 3'd1;
                        end
                        nmea_rmc_pkg::FLD_LON_HEMI: begin
                            if (r_digit_pos == '0 && i_rx_char == nmea_rmc_pkg::CH_W) begin
                                n_hemi[1] = 1'b1;
                            end
                            n_digit_pos = 3'd1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
        end
    end

    // control registers and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_year_min       <= nmea_rmc_pkg::YEAR_MIN_RESET;
            r_year_max       <= nmea_rmc_pkg::YEAR_MAX_RESET;
            r_prefix_pos     <= '0;
            r_in_sentence    <= 1'b0;
            r_field_count    <= '0;
            r_digit_pos      <= '0;
            r_frac_digits    <= '0;
            r_after_point    <= 1'b0;
            r_clock_set_done <= 1'b0;
            r_fix_held       <= 1'b0;
        end else begin
            r_prefix_pos     <= n_prefix_pos;
            r_in_sentence    <= n_in_sentence;
            r_field_count    <= n_field_count;
            r_digit_pos      <= n_digit_pos;
            r_frac_digits    <= n_frac_digits;
            r_after_point    <= n_after_point;
            r_clock_set_done <= n_clock_set_done;
            r_fix_held       <= n_fix_held;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    nmea_rmc_pkg::CFG_YEAR_MIN: r_year_min <= i_cfg_data;
                    nmea_rmc_pkg::CFG_YEAR_MAX: r_year_max <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // accumulators, cleared by the start of each sentence
    always_ff @(posedge i_clk) begin
        r_time_acc  <= n_time_acc;
        r_date_acc  <= n_date_acc;
        r_status_ok <= n_status_ok;
        r_hemi      <= n_hemi;
        r_lat_whole <= n_lat_whole;
        r_lat_deg   <= n_lat_deg;
        r_lat_rem   <= n_lat_rem;
        r_lat_frac  <= n_lat_frac;
        r_lon_whole <= n_lon_whole;
        r_lon_deg   <= n_lon_deg;
        r_lon_rem   <= n_lon_rem;
        r_lon_frac  <= n_lon_frac;
    end

    // microdegrees = deg * 1e6 + floor(minutes_scaled / 6)
    assign lat_div_prod = nmea_rmc_pkg::PROD_W'(r_lat_minv)
                          * nmea_rmc_pkg::PROD_W'(nmea_rmc_pkg::DIV6_MULT);
    assign lon_div_prod = nmea_rmc_pkg::PROD_W'(r_lon_minv)
                          * nmea_rmc_pkg::PROD_W'(nmea_rmc_pkg::DIV6_MULT);
    assign lat_sum = nmea_rmc_pkg::LAT_SUM_W'(r_lat_deg * nmea_rmc_pkg::MICRO + r_lat_q);
    assign lon_sum = nmea_rmc_pkg::LON_SUM_W'(r_lon_deg * nmea_rmc_pkg::MICRO + r_lon_q);

    always_ff @(posedge i_clk) begin
        r_lat_minv <= nmea_rmc_pkg::MINV_W'(r_lat_rem * nmea_rmc_pkg::FRAC_SCALE + r_lat_frac);
        r_lon_minv <= nmea_rmc_pkg::MINV_W'(r_lon_rem * nmea_rmc_pkg::FRAC_SCALE + r_lon_frac);
        r_lat_q    <= lat_div_prod[nmea_rmc_pkg::DIV6_SHIFT +: nmea_rmc_pkg::Q_W];
        r_lon_q    <= lon_div_prod[nmea_rmc_pkg::DIV6_SHIFT +: nmea_rmc_pkg::Q_W];
        r_lat_out  <= (lat_sum > nmea_rmc_pkg::LAT_OUT_MAX)
                      ? nmea_rmc_pkg::LAT_OUT_W'(nmea_rmc_pkg::LAT_OUT_MAX)
                      : lat_sum[nmea_rmc_pkg::LAT_OUT_W-1:0];
        r_lon_out  <= (lon_sum > nmea_rmc_pkg::LON_OUT_MAX)
                      ? nmea_rmc_pkg::LON_OUT_W'(nmea_rmc_pkg::LON_OUT_MAX)
                      : lon_sum[nmea_rmc_pkg::LON_OUT_W-1:0];
    end

    always_comb begin
        res.hour           = r_time_acc[0];
        res.minute         = r_time_acc[1];
        res.second         = r_time_acc[2];
        res.day            = r_date_acc[0];
        res.month          = r_date_acc[1];
        res.year           = r_date_acc[2];
        res.position_valid = r_status_ok;
        res.lat_microdeg   = r_lat_out;
        res.lat_south      = r_hemi[0];
        res.lon_microdeg   = r_lon_out;
        res.lon_west       = r_hemi[1];
        res.event_res      = ev;
    end

    // result register with skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (out_take) begin
                    r_out        <= r_skid;
                    r_skid_valid <= 1'b0;
                end
            end else if (res_v) begin
                if (!r_out_valid || out_take) begin
                    r_out       <= res;
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid       <= res;
                    r_skid_valid <= 1'b1;
                end
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid          = r_out_valid;
    assign o_hour           = r_out.hour;
    assign o_minute         = r_out.minute;
    assign o_second         = r_out.second;
    assign o_day            = r_out.day;
    assign o_month          = r_out.month;
    assign o_year           = r_out.year;
    assign o_position_valid = r_out.position_valid;
    assign o_lat_microdeg   = r_out.lat_microdeg;
    assign o_lat_south      = r_out.lat_south;
    assign o_lon_microdeg   = r_out.lon_microdeg;
    assign o_lon_west       = r_out.lon_west;
    assign o_event_res      = r_out.event_res;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word held without a result word in front");

    a_clock_set_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clock_set_done |=> r_clock_set_done)
        else $error("clock-set history lost outside reset");

    a_fix_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_event_res[nmea_rmc_pkg::EV_FIX_GAINED] && !o_position_valid))
        else $error("fix-gained event on a word without a valid position");

    a_result_ends_sentence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_v |=> !r_in_sentence || (r_prefix_pos == 3'd1))
        else $error("sentence still open after its result");

endmodule

[tb/tb_nmea_rmc_sentence_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nmea_rmc_sentence_parser
// Feeds character streams of RMC sentences, broken sentences and line noise
// through the parser with random gaps and receiver stalls. Every accepted
// character also steps a local model of the parser. Each result word is
// checked field by field against the oldest predicted report. The year
// window is rewritten between phases while the parser is idle.
// ----------------------------------------------------------------------------
module tb_nmea_rmc_sentence_parser;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RANDOM_CHARS   = 1000;
    localparam logic [55:0] RMC_HEAD = {nmea_rmc_pkg::CH_DOLLAR, nmea_rmc_pkg::CH_G,
                                        nmea_rmc_pkg::CH_P, nmea_rmc_pkg::CH_R,
                                        nmea_rmc_pkg::CH_M, nmea_rmc_pkg::CH_C,
                                        nmea_rmc_pkg::CH_COMMA};

    logic                                i_clk;
    logic                                i_rst_n     = 1'b0;
    logic                                i_valid     = 1'b0;
    logic [7:0]                          i_rx_char   = 8'h00;
    logic                                i_stall     = 1'b0;
    logic                                i_cfg_valid = 1'b0;
    logic [nmea_rmc_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [nmea_rmc_pkg::YEAR_W-1:0]     i_cfg_data  = '0;
    logic                                o_stall;
    logic                                o_valid;
    logic                                o_cfg_ready;
    logic [nmea_rmc_pkg::PAIR_W-1:0]     o_hour, o_minute, o_second, o_day, o_month, o_year;
    logic                                o_position_valid, o_lat_south, o_lon_west;
    logic [nmea_rmc_pkg::LAT_OUT_W-1:0]  o_lat_microdeg;
    logic [nmea_rmc_pkg::LON_OUT_W-1:0]  o_lon_microdeg;
    logic [nmea_rmc_pkg::EVENT_W-1:0]    o_event_res;

    nmea_rmc_sentence_parser dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_rx_char        (i_rx_char),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_hour           (o_hour),
        .o_minute         (o_minute),
        .o_second         (o_second),
        .o_day            (o_day),
        .o_month          (o_month),
        .o_year           (o_year),
        .o_position_valid (o_position_valid),
        .o_lat_microdeg   (o_lat_microdeg),
        .o_lat_south      (o_lat_south),
        .o_lon_microdeg   (o_lon_microdeg),
        .o_lon_west       (o_lon_west),
        .o_event_res      (o_event_res),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // local copy of the parser state
    // ------------------------------------------------------------------
    logic [nmea_rmc_pkg::YEAR_W-1:0] yr_lo = nmea_rmc_pkg::YEAR_MIN_RESET;
    logic [nmea_rmc_pkg::YEAR_W-1:0] yr_hi = nmea_rmc_pkg::YEAR_MAX_RESET;
    logic [2:0]        head_pos = '0;
    bit                in_rmc = 1'b0;
    logic [3:0]        fld = '0;
    logic [2:0]        dpos = '0;
    logic [6:0]        hms [3] = '{default: '0};
    logic [6:0]        dmy [3] = '{default: '0};
    bit                stat_a = 1'b0;
    int unsigned       lat_w = 0, lat_f = 0, lon_w = 0, lon_f = 0;
    int unsigned       frac_n = 0;
    bit                seen_pt = 1'b0;
    logic [1:0]        hemi = '0;
    bit                clock_set = 1'b0;
    bit                fix_on = 1'b0;

    nmea_rmc_pkg::t_result pending_reports [$];
    logic [7:0]  char_q [$];
    int          chars_queued = 0;
    int          chars_taken = 0;
    int          reports_seen = 0;
    int          windows_written = 0;
    int          mismatches = 0;
    int          quiet_cycles = 0;
    int          in_idle_pct = 0;
    int          out_idle_pct = 0;
    int          in_gap = 0;
    int          out_gap = 0;

    function automatic bit is_num(logic [7:0] c);
        return (c >= nmea_rmc_pkg::CH_ZERO) && (c <= nmea_rmc_pkg::CH_NINE);
    endfunction

    function automatic longint unsigned pow_ten(int unsigned n);
        longint unsigned p;
        p = 1;
        for (int i = 0; i < n; i++) p = p * 10;
        return p;
    endfunction

    function automatic void new_field();
        dpos = '0;
        frac_n = 0;
        seen_pt = 1'b0;
    endfunction

    function automatic void take_pair(bit is_date, logic [7:0] c);
        int k;
        k = dpos >> 1;
        if (dpos < nmea_rmc_pkg::PAIR_DIGITS && is_num(c)) begin
            if (is_date) dmy[k] = 7'(dmy[k] * 10 + (c - nmea_rmc_pkg::CH_ZERO));
            else hms[k] = 7'(hms[k] * 10 + (c - nmea_rmc_pkg::CH_ZERO));
            dpos = dpos + 1'b1;
        end else begin
            dpos = nmea_rmc_pkg::DP_STOP;
        end
    endfunction

    function automatic void take_coord(bit is_lon, logic [7:0] c);
        int unsigned v;
        if (dpos == nmea_rmc_pkg::DP_STOP) return;
        if (is_num(c)) begin
            if (seen_pt) begin
                if (frac_n < nmea_rmc_pkg::FRAC_DIGITS) begin
                    if (is_lon) lon_f = lon_f * 10 + (c - nmea_rmc_pkg::CH_ZERO);
                    else lat_f = lat_f * 10 + (c - nmea_rmc_pkg::CH_ZERO);
                    frac_n++;
                end
            end else if (is_lon) begin
                v = lon_w * 10 + (c - nmea_rmc_pkg::CH_ZERO);
                lon_w = (v > nmea_rmc_pkg::LON_WHOLE_MAX) ? nmea_rmc_pkg::LON_WHOLE_MAX : v;
            end else begin
                v = lat_w * 10 + (c - nmea_rmc_pkg::CH_ZERO);
                lat_w = (v > nmea_rmc_pkg::LAT_WHOLE_MAX) ? nmea_rmc_pkg::LAT_WHOLE_MAX : v;
            end
        end else if (c == nmea_rmc_pkg::CH_POINT && !seen_pt) begin
            seen_pt = 1'b1;
        end else begin
            dpos = nmea_rmc_pkg::DP_STOP;
        end
    endfunction

    // pad the minute decimals out to the full fraction width
    function automatic void close_field();
        if (fld == nmea_rmc_pkg::FLD_LAT)
            lat_f = lat_f * pow_ten(nmea_rmc_pkg::FRAC_DIGITS - frac_n);
        else if (fld == nmea_rmc_pkg::FLD_LON)
            lon_f = lon_f * pow_ten(nmea_rmc_pkg::FRAC_DIGITS - frac_n);
    endfunction

    function automatic longint unsigned to_micro(int unsigned whole, int unsigned frac,
                                                 longint unsigned cap);
        longint unsigned scale, minv, v;
        scale = pow_ten(nmea_rmc_pkg::FRAC_DIGITS);
        minv = 64'(whole % 100) * scale + frac;
        v = 64'(whole / 100) * 64'd1000000 + (minv * 64'd1000000) / (64'd60 * scale);
        return (v > cap) ? cap : v;
    endfunction

    function automatic bit parse_char(logic [7:0] c, output nmea_rmc_pkg::t_result rep);
        logic [nmea_rmc_pkg::EVENT_W-1:0] ev;
        rep = '0;
        ev = '0;
        if (c == nmea_rmc_pkg::CH_DOLLAR) begin
            in_rmc = 1'b1;
            head_pos = 3'd1;
            fld = '0;
            new_field();
            for (int i = 0; i < 3; i++) begin
                hms[i] = '0;
                dmy[i] = '0;
            end
            stat_a = 1'b0;
            lat_w = 0;
            lat_f = 0;
            lon_w = 0;
            lon_f = 0;
            hemi = '0;
            return 1'b0;
        end
        if (!in_rmc) return 1'b0;
        if (head_pos < nmea_rmc_pkg::PREFIX_LEN) begin
            if (c == RMC_HEAD[55 - 8 * head_pos -: 8]) begin
                head_pos = head_pos + 1'b1;
                if (head_pos == nmea_rmc_pkg::PREFIX_LEN) begin
                    fld = nmea_rmc_pkg::FLD_TIME;
                    new_field();
                end
            end else begin
                in_rmc = 1'b0;
            end
            return 1'b0;
        end
        if (c == nmea_rmc_pkg::CH_STAR || c == nmea_rmc_pkg::CH_CR
            || c == nmea_rmc_pkg::CH_LF) begin
            in_rmc = 1'b0;
            if (fld < nmea_rmc_pkg::FLD_DATE) return 1'b0;
            close_field();
            if (dmy[2] >= yr_lo && dmy[2] <= yr_hi && !clock_set) begin
                ev[nmea_rmc_pkg::EV_SET_CLOCK] = 1'b1;
                clock_set = 1'b1;
            end
            if (stat_a) begin
                if (!fix_on) ev[nmea_rmc_pkg::EV_FIX_GAINED] = 1'b1;
                fix_on = 1'b1;
            end else begin
                fix_on = 1'b0;
            end
            rep.hour           = hms[0];
            rep.minute         = hms[1];
            rep.second         = hms[2];
            rep.day            = dmy[0];
            rep.month          = dmy[1];
            rep.year           = dmy[2];
            rep.position_valid = stat_a;
            rep.lat_microdeg   = nmea_rmc_pkg::LAT_OUT_W'(
                                     to_micro(lat_w, lat_f, nmea_rmc_pkg::LAT_OUT_MAX));
            rep.lat_south      = hemi[0];
            rep.lon_microdeg   = nmea_rmc_pkg::LON_OUT_W'(
                                     to_micro(lon_w, lon_f, nmea_rmc_pkg::LON_OUT_MAX));
            rep.lon_west       = hemi[1];
            rep.event_res      = ev;
            return 1'b1;
        end
        if (c == nmea_rmc_pkg::CH_COMMA) begin
            close_field();
            if (fld < nmea_rmc_pkg::FLD_MAX) fld = fld + 1'b1;
            new_field();
            return 1'b0;
        end
        case (fld)
            nmea_rmc_pkg::FLD_TIME:     take_pair(1'b0, c);
            nmea_rmc_pkg::FLD_DATE:     take_pair(1'b1, c);
            nmea_rmc_pkg::FLD_STATUS: begin
                stat_a = (dpos == 0) && (c == nmea_rmc_pkg::CH_A);
                if (dpos < nmea_rmc_pkg::STATUS_CAP) dpos = dpos + 1'b1;
            end
            nmea_rmc_pkg::FLD_LAT:      take_coord(1'b0, c);
            nmea_rmc_pkg::FLD_LON:      take_coord(1'b1, c);
            nmea_rmc_pkg::FLD_LAT_HEMI: begin
                if (dpos == 0 && c == nmea_rmc_pkg::CH_S) hemi[0] = 1'b1;
                dpos = 3'd1;
            end
            nmea_rmc_pkg::FLD_LON_HEMI: begin
                if (dpos == 0 && c == nmea_rmc_pkg::CH_W) hemi[1] = 1'b1;
                dpos = 3'd1;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic void check_field(string name, longint unsigned want_v,
                                        longint unsigned got_v);
        if (want_v != got_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------
    // character driver
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        nmea_rmc_pkg::t_result rep;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                chars_taken++;
                if (parse_char(i_rx_char, rep)) pending_reports.push_back(rep);
            end
            if (!i_valid || !o_stall) begin
                if (in_gap > 0) begin
                    i_valid <= 1'b0;
                    in_gap <= in_gap - 1;
                end else if (char_q.size() > 0 && $urandom_range(99) < in_idle_pct) begin
                    i_valid <= 1'b0;
                    in_gap <= $urandom_range(17);
                end else if (char_q.size() > 0) begin
                    i_valid <= 1'b1;
                    i_rx_char <= char_q.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor and receiver stall
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        nmea_rmc_pkg::t_result want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                reports_seen++;
                if (pending_reports.size() == 0) begin
                    $error("result word with no sentence pending");
                    mismatches++;
                end else begin
                    want = pending_reports.pop_front();
                    check_field("hour", want.hour, o_hour);
                    check_field("minute", want.minute, o_minute);
                    check_field("second", want.second, o_second);
                    check_field("day", want.day, o_day);
                    check_field("month", want.month, o_month);
                    check_field("year", want.year, o_year);
                    check_field("position_valid", want.position_valid, o_position_valid);
                    check_field("lat_microdeg", want.lat_microdeg, o_lat_microdeg);
                    check_field("lat_south", want.lat_south, o_lat_south);
                    check_field("lon_microdeg", want.lon_microdeg, o_lon_microdeg);
                    check_field("lon_west", want.lon_west, o_lon_west);
                    check_field("event_res", want.event_res, o_event_res);
                end
            end
            if (out_gap > 0) begin
                i_stall <= 1'b1;
                out_gap <= out_gap - 1;
            end else if ($urandom_range(99) < out_idle_pct) begin
                i_stall <= 1'b1;
                out_gap <= $urandom_range(17);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        @(negedge i_clk);
        while (quiet_cycles < WATCHDOG_LIMIT) @(negedge i_clk);
        $display("no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic put_ch(logic [7:0] c);
        char_q.push_back(c);
        chars_queued++;
    endtask

    task automatic put_str(string s);
        for (int i = 0; i < s.len(); i++) put_ch(s[i]);
    endtask

    task automatic put_digits(int n);
        for (int i = 0; i < n; i++) put_ch(nmea_rmc_pkg::CH_ZERO + 8'($urandom_range(9)));
    endtask

    task automatic maybe_junk();
        if ($urandom_range(99) < 3) put_ch(8'($urandom_range(255)));
    endtask

    task automatic put_pairs();
        put_digits(($urandom_range(99) < 75) ? 6 : $urandom_range(8));
        if ($urandom_range(99) < 15) put_str(".00");
        maybe_junk();
    endtask

    task automatic put_coord(int whole_n);
        put_digits(($urandom_range(99) < 75) ? whole_n : $urandom_range(8));
        if ($urandom_range(99) < 85) begin
            put_ch(nmea_rmc_pkg::CH_POINT);
            put_digits($urandom_range(7));
        end
        maybe_junk();
    endtask

    task automatic put_flag(string usual, string other);
        case ($urandom_range(9))
            0: ;
            1: put_str({usual, other});
            2: put_ch(8'($urandom_range(255)));
            3, 4, 5, 6: put_str(usual);
            default: put_str(other);
        endcase
    endtask

    task automatic put_random_sentence();
        string hexd;
        int last_field, cut;
        hexd = "0123456789ABCDEF";
        if ($urandom_range(99) < 8) begin
            put_str("$GP");
            put_ch(8'($urandom_range(255)));
            put_str("MC,");
        end else begin
            put_str("$GPRMC,");
        end
        last_field = ($urandom_range(99) < 85) ? 9 + $urandom_range(3) : 9 + $urandom_range(9);
        cut = ($urandom_range(99) < 8) ? $urandom_range(1, 9) : 0;
        for (int f = 1; f <= last_field && f != cut; f++) begin
            if (f > 1) put_ch(nmea_rmc_pkg::CH_COMMA);
            case (f)
                1, 9: put_pairs();
                2: put_flag("A", "V");
                3: put_coord(4);
                4: put_flag("S", "N");
                5: put_coord(5);
                6: put_flag("W", "E");
                default: put_digits($urandom_range(4));
            endcase
        end
        case ($urandom_range(9))
            0, 1, 2, 3, 4: begin
                put_ch(nmea_rmc_pkg::CH_STAR);
                put_ch(hexd[$urandom_range(15)]);
                put_ch(hexd[$urandom_range(15)]);
                put_ch(nmea_rmc_pkg::CH_CR);
                put_ch(nmea_rmc_pkg::CH_LF);
            end
            5, 6: begin
                put_ch(nmea_rmc_pkg::CH_CR);
                put_ch(nmea_rmc_pkg::CH_LF);
            end
            7: put_ch(nmea_rmc_pkg::CH_LF);
            8: put_ch(nmea_rmc_pkg::CH_CR);
            default: ;
        endcase
        if ($urandom_range(99) < 15) repeat ($urandom_range(1, 6)) put_ch(8'($urandom_range(255)));
    endtask

    task automatic write_reg(logic [nmea_rmc_pkg::CFG_IDX_W-1:0] idx,
                             logic [nmea_rmc_pkg::YEAR_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        while (!o_cfg_ready) @(negedge i_clk);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == nmea_rmc_pkg::CFG_YEAR_MIN) yr_lo = val;
        else yr_hi = val;
    endtask

    task automatic set_window(logic [nmea_rmc_pkg::YEAR_W-1:0] lo,
                              logic [nmea_rmc_pkg::YEAR_W-1:0] hi);
        if ($urandom_range(1)) begin
            write_reg(nmea_rmc_pkg::CFG_YEAR_MAX, hi);
            write_reg(nmea_rmc_pkg::CFG_YEAR_MIN, lo);
        end else begin
            write_reg(nmea_rmc_pkg::CFG_YEAR_MIN, lo);
            write_reg(nmea_rmc_pkg::CFG_YEAR_MAX, hi);
        end
        windows_written++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        while (char_q.size() != 0 || i_valid || pending_reports.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic int pick_pct();
        case ($urandom_range(2))
            0: return 0;
            1: return 10;
            default: return 35;
        endcase
    endfunction

    initial begin
        int random_start;
        logic [nmea_rmc_pkg::YEAR_W-1:0] lo, hi;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset window 21..50, years either side of it
        in_idle_pct = 15;
        out_idle_pct = 15;
        put_str("$GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W*6A");
        put_ch(nmea_rmc_pkg::CH_CR);
        put_ch(nmea_rmc_pkg::CH_LF);
        put_str("$GPRMC,235959,A,9000.00000,S,18000.00000,W,0.0,0.0,311220*");
        put_str("$GPRMC,000000,V,0000.00000,N,00000.00000,E,,,010151");
        put_ch(nmea_rmc_pkg::CH_LF);
        put_str("$GPRMC,999999,A,9999.99999,S,99999.99999,W,,,999999*");
        put_str("$GPRMC,1,AV,9999999,SX,99999999,WE,,,7");
        put_ch(nmea_rmc_pkg::CH_CR);
        put_str("$GPRMC,,,,,,,,,");
        put_ch(nmea_rmc_pkg::CH_LF);
        put_str("$GPRMC,12 34,a,48.07.03,s,1-2,w,,,12345678,,,,,,,,,,*");
        put_str("$GPRMC,123519,A,4807.0381234,N,01131.99999999,E,,,230394*");
        put_str("$GPRMC,1,A,2,N,3,E,4,5*");
        put_str("$GPGGA,123519,A,,,,,,,230394*");
        put_str("$GPR$GPRMC,010203,A,,,,,,,040506*");
        put_str("GPRMC,1,A,,,,,,,2*");
        put_ch(8'h00);
        put_ch(8'hFF);
        put_ch(8'h80);
        put_ch(8'h7F);
        put_str("$GPRMC,12");
        put_ch(8'hFF);
        put_str("34,A,,,,,,,010101*");
        put_str("$GPRMC,,A,.5,N,12.,E,,,*");
        drain();

        // empty window: nothing may set the clock
        set_window(7'd60, 7'd40);
        put_str("$GPRMC,010101,A,,,,,,,010145*");
        put_str("$GPRMC,010101,V,,,,,,,010160*");
        put_str("$GPRMC,010101,A,,,,,,,010140*");
        drain();

        // lowest single-year window: clock is set once only
        set_window(7'd0, 7'd0);
        put_str("$GPRMC,010101,A,,,,,,,010101*");
        put_str("$GPRMC,010101,A,,,,,,,010100*");
        put_str("$GPRMC,020202,A,,,,,,,020200*");
        drain();

        set_window(7'd99, 7'd99);
        put_str("$GPRMC,030303,A,,,,,,,030399*");
        drain();

        random_start = chars_queued;
        while (chars_queued - random_start < RANDOM_CHARS) begin
            case ($urandom_range(4))
                0: begin lo = 7'd0; hi = 7'd99; end
                1: begin lo = 7'd99; hi = 7'd0; end
                2: begin
                    lo = nmea_rmc_pkg::YEAR_MIN_RESET;
                    hi = nmea_rmc_pkg::YEAR_MAX_RESET;
                end
                3: begin lo = 7'd99; hi = 7'd99; end
                default: begin lo = 7'($urandom_range(99)); hi = 7'($urandom_range(99)); end
            endcase
            set_window(lo, hi);
            // closing stretch runs flat out on both sides
            if (chars_queued - random_start >= RANDOM_CHARS * 3 / 4) begin
                in_idle_pct = 0;
                out_idle_pct = 0;
            end else begin
                in_idle_pct = pick_pct();
                out_idle_pct = pick_pct();
            end
            repeat (8) put_random_sentence();
            drain();
        end

        $display("run covered %0d characters and %0d result words", chars_taken, reports_seen);
        $display("year window rewritten %0d times, %0d field mismatches",
                 windows_written, mismatches);
        if (mismatches == 0 && pending_reports.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[sim.f]
design/nmea_rmc_pkg.sv
design/nmea_rmc_sentence_parser.sv
tb/tb_nmea_rmc_sentence_parser.sv
